>>> design/cbpc_pkg.sv
// ----------------------------------------------------------------------------
// cbpc_pkg
// Shared widths, request and register codes, and the command and
// configuration types of the cell balancer.
// ----------------------------------------------------------------------------
package cbpc_pkg;

   // payload widths
   localparam int CELL_W     = 4;
   localparam int THR_W      = 8;
   localparam int MAP_W      = 12;
   localparam int CNT_W      = 16;
   localparam int ACC_W      = 32;
   localparam int CUR_W      = 16;
   localparam int STEP_W     = 16;
   localparam int REQ_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // cells that own a period length and a bitmap bit
   localparam int PERIOD_CELLS = 12;
   localparam logic [CNT_W-1:0] LEN_RESET = 16'd255;

   // command queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // request codes on req_type
   localparam logic [REQ_W-1:0] REQ_TICK_FAST = 3'd0;
   localparam logic [REQ_W-1:0] REQ_TICK_SLOW = 3'd1;
   localparam logic [REQ_W-1:0] REQ_SET_THR   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SET_MAP   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

   // register indexes on csr_index
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MID  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP        = 3'd4;

   typedef enum logic [2:0] {
      OP_TICK_FAST,
      OP_TICK_SLOW,
      OP_SET_THR,
      OP_SET_MAP,
      OP_READ,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [CELL_W-1:0]        cell_idx;
      logic                     cell_ok;
      logic [THR_W-1:0]         thr;
      logic [MAP_W-1:0]         map;
      logic signed [CUR_W-1:0]  cur;
   } cmd_type;

   typedef struct packed {
      logic                                  pwm_mode;
      logic [PERIOD_CELLS-1:0][CNT_W-1:0]    period;
      logic [STEP_W-1:0]                     step;
   } cfg_type;

endpackage

>>> design/cell_balancer_pwm_coulomb.sv
// ----------------------------------------------------------------------------
// cell_balancer_pwm_coulomb
// Per-cell balancer: PWM discharger bitmap and per-cell charge accounting.
// ----------------------------------------------------------------------------
// results: set, read and unknown requests put their result in the result register
//   as they leave the queue; fast and slow ticks put it there when the walk ends
// throughput: one set or read per cycle while the result register is empty or popped;
//   a tick holds the back until its one-cell-per-cycle walk through the single accumulator adder ends
// reset: synchronous; clears the queue, result, counters, thresholds,
//   accumulators and bitmap, and loads the register reset values
module cell_balancer_pwm_coulomb
   import cbpc_pkg::*;
#(
   parameter int CELLS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   // request queue side
   input  logic                     push,
   output logic                     full,
   input  logic [REQ_W-1:0]         req_type,
   input  logic [CELL_W-1:0]        req_cell_index,
   input  logic [THR_W-1:0]         req_threshold_value,
   input  logic [MAP_W-1:0]         req_bitmap_value,
   input  logic signed [CUR_W-1:0]  req_stack_current,
   // result queue side
   output logic                     empty,
   input  logic                     pop,
   output logic [MAP_W-1:0]         rsp_discharger_bits,
   output logic signed [ACC_W-1:0]  rsp_charge_value,
   // register writes
   input  logic                     valid,
   output logic                     ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   cfg_type  cfg_ff;
   logic     q_push;
   cmd_type  q_cmd;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   cmd_type  q_head;
   logic     rsp_valid;

   assign ready = 1'b1;
   assign full  = q_full;
   assign empty = !rsp_valid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_mode <= 1'b0;
         cfg_ff.period   <= {PERIOD_CELLS{LEN_RESET}};
         cfg_ff.step     <= '0;
      end else if (valid && ready) begin
         case (csr_index)
            CSR_PWM_MODE:    cfg_ff.pwm_mode     <= csr_data[0];
            CSR_PERIOD_LOW:  cfg_ff.period[3:0]  <= csr_data;
            CSR_PERIOD_MID:  cfg_ff.period[7:4]  <= csr_data;
            CSR_PERIOD_HIGH: cfg_ff.period[11:8] <= csr_data;
            CSR_STEP:        cfg_ff.step         <= csr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request decode
   cbpc_front #(
      .CELLS (CELLS)
   ) u_front (
      .push                (push),
      .req_type            (req_type),
      .req_cell_index      (req_cell_index),
      .req_threshold_value (req_threshold_value),
      .req_bitmap_value    (req_bitmap_value),
      .req_stack_current   (req_stack_current),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_cmd               (q_cmd)
   );

   // command queue
   cbpc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_cmd   (q_cmd),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   // execution and result register
   cbpc_back #(
      .CELLS (CELLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_pop    (pop),
      .rsp_valid  (rsp_valid),
      .rsp_bits   (rsp_discharger_bits),
      .rsp_charge (rsp_charge_value)
   );

endmodule

>>> design/cbpc_front.sv
// ----------------------------------------------------------------------------
// cbpc_front
// Accepts request beats, decodes the request kind, range-checks the cell
// index and masks the bitmap, and hands a command to the queue.
// ----------------------------------------------------------------------------
module cbpc_front
   import cbpc_pkg::*;
#(
   parameter int CELLS = 12
) (
   input  logic                     push,
   input  logic [REQ_W-1:0]         req_type,
   input  logic [CELL_W-1:0]        req_cell_index,
   input  logic [THR_W-1:0]         req_threshold_value,
   input  logic [MAP_W-1:0]         req_bitmap_value,
   input  logic signed [CUR_W-1:0]  req_stack_current,
   input  logic                     q_full,
   output logic                     q_push,
   output cmd_type                  q_cmd
);

   localparam int MAP_CELLS = (CELLS < MAP_W) ? CELLS : MAP_W;
   localparam logic [MAP_W-1:0] MAP_MASK = MAP_W'((1 << MAP_CELLS) - 1);

   assign q_push = push && !q_full;

   // classify the request
   always_comb begin
      q_cmd.cell_idx = req_cell_index;
      q_cmd.cell_ok  = ({1'b0, req_cell_index} < (CELL_W + 1)'(CELLS));
      q_cmd.thr      = req_threshold_value;
      q_cmd.map      = req_bitmap_value & MAP_MASK;
      q_cmd.cur      = req_stack_current;
      case (req_type)
         REQ_TICK_FAST: q_cmd.op = OP_TICK_FAST;
         REQ_TICK_SLOW: q_cmd.op = OP_TICK_SLOW;
         REQ_SET_THR:   q_cmd.op = OP_SET_THR;
         REQ_SET_MAP:   q_cmd.op = OP_SET_MAP;
         REQ_READ:      q_cmd.op = OP_READ;
         default:       q_cmd.op = OP_NONE;
      endcase
   end

endmodule

>>> design/cbpc_queue.sv
// ----------------------------------------------------------------------------
// cbpc_queue
// Short command queue that lets the front keep taking beats while the
// back walks the cells.
// ----------------------------------------------------------------------------
module cbpc_queue
   import cbpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_push,
   input  cmd_type q_cmd,
   output logic    q_full,
   input  logic    q_pop,
   output logic    q_empty,
   output cmd_type q_head
);

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign q_full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (q_push) begin
         entry_ff[wr_ptr_ff] <= q_cmd;
      end
   end

endmodule

>>> design/cbpc_back.sv
// ----------------------------------------------------------------------------
// cbpc_back
// Executes queued commands. Ticks walk the cells one per cycle through a
// single counter step and a single accumulator adder; other commands
// finish in the cycle they leave the queue. Holds the result register.
// ----------------------------------------------------------------------------
module cbpc_back
   import cbpc_pkg::*;
#(
   parameter int CELLS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     q_empty,
   input  cmd_type                  q_head,
   output logic                     q_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_valid,
   output logic [MAP_W-1:0]         rsp_bits,
   output logic signed [ACC_W-1:0]  rsp_charge
);

   localparam int IDX_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int MAP_CELLS = (CELLS < MAP_W) ? CELLS : MAP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

   typedef enum logic [0:0] {
      S_IDLE,
      S_WALK
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     slow_ff, slow_in;
   logic signed [CUR_W-1:0]  cur_ff, cur_in;
   logic [MAP_W-1:0]         map_ff, map_in;
   logic [MAP_W-1:0]         newmap_ff, newmap_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MAP_W-1:0]         bits_ff, bits_in;
   logic [ACC_W-1:0]         charge_ff, charge_in;

   // per-cell state
   logic [CNT_W-1:0]         cnt_ff [CELLS];
   logic [THR_W-1:0]         thr_ff [CELLS];
   logic [ACC_W-1:0]         acc_ff [CELLS];

   logic                     start;
   logic                     slot_free;
   logic                     last;
   logic [IDX_W-1:0]         acc_addr;
   logic [ACC_W-1:0]         acc_rd;
   logic [ACC_W-1:0]         addend;
   logic [ACC_W-1:0]         acc_in;
   logic                     acc_we;
   logic [CELL_W-1:0]        idx_w;
   logic [CNT_W-1:0]         period_cur;
   logic [CNT_W-1:0]         cnt_cur;
   logic [CNT_W-1:0]         cnt_in;
   logic                     cnt_we;
   logic                     in_map;
   logic                     bit_pwm;
   logic                     bit_on;
   logic                     thr_we;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bits   = bits_ff;
   assign rsp_charge = charge_ff;

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign start     = (state_ff == S_IDLE) && !q_empty && slot_free;
   assign q_pop     = start;
   assign last      = (idx_ff == LAST_IDX);

   // one accumulator read port, shared by the walk and by reads
   assign acc_addr = (state_ff == S_WALK) ? idx_ff : q_head.cell_idx[IDX_W-1:0];
   assign acc_rd   = acc_ff[acc_addr];

   // pwm counter step and discharger bit of the walked cell
   always_comb begin
      idx_w      = CELL_W'(idx_ff);
      in_map     = (idx_w < CELL_W'(MAP_CELLS));
      period_cur = '0;
      if (idx_w < CELL_W'(PERIOD_CELLS)) begin
         period_cur = cfg.period[idx_w];
      end
      cnt_cur = cnt_ff[idx_ff];
      cnt_in  = (cnt_cur < period_cur) ? cnt_cur + 1'b1 : '0;
      bit_pwm = in_map && (cnt_in < CNT_W'(thr_ff[idx_ff]));
      bit_on  = cfg.pwm_mode ? bit_pwm : (in_map && map_ff[idx_w]);
   end

   // accumulator adder: current on slow ticks, minus step on fast ticks for cells whose discharger bit is on
   always_comb begin
      if (slow_ff) begin
         addend = {{(ACC_W - CUR_W){cur_ff[CUR_W-1]}}, cur_ff};
      end else if (bit_on) begin
         addend = ~{{(ACC_W - STEP_W){1'b0}}, cfg.step} + 1'b1;
      end else begin
         addend = '0;
      end
      acc_in    = acc_rd + addend;
      newmap_in = newmap_ff | (bit_pwm ? (MAP_W'(1) << idx_w) : '0);
   end

   // command sequencing
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      slow_in      = slow_ff;
      cur_in       = cur_ff;
      map_in       = map_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      bits_in      = bits_ff;
      charge_in    = charge_ff;
      acc_we       = 1'b0;
      cnt_we       = 1'b0;
      thr_we       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               charge_in = '0;
               case (q_head.op)
                  OP_TICK_FAST, OP_TICK_SLOW: begin
                     state_in = S_WALK;
                     idx_in   = '0;
                     slow_in  = (q_head.op == OP_TICK_SLOW);
                     cur_in   = q_head.cur;
                  end
                  OP_SET_THR: begin
                     thr_we = q_head.cell_ok;
                  end
                  OP_SET_MAP: begin
                     map_in = q_head.map;
                  end
                  OP_READ: begin
                     charge_in = q_head.cell_ok ? acc_rd : '0;
                  end
                  default: begin
                  end
               endcase
               if (q_head.op != OP_TICK_FAST && q_head.op != OP_TICK_SLOW) begin
                  rsp_valid_in = 1'b1;
                  bits_in      = map_in;
               end
            end
         end
         S_WALK: begin
            acc_we = 1'b1;
            cnt_we = cfg.pwm_mode && !slow_ff;
            idx_in = idx_ff + 1'b1;
            if (last) begin
               state_in     = S_IDLE;
               map_in       = (cfg.pwm_mode && !slow_ff) ? newmap_in : map_ff;
               rsp_valid_in = 1'b1;
               bits_in      = map_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, per-cell storage and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         map_ff       <= '0;
         newmap_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CELLS; i++) begin
            cnt_ff[i] <= '0;
            thr_ff[i] <= '0;
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         map_ff       <= map_in;
         newmap_ff    <= (state_ff == S_WALK) ? newmap_in : '0;
         rsp_valid_ff <= rsp_valid_in;
         if (acc_we) begin
            acc_ff[idx_ff] <= acc_in;
         end
         if (cnt_we) begin
            cnt_ff[idx_ff] <= cnt_in;
         end
         if (thr_we) begin
            thr_ff[q_head.cell_idx[IDX_W-1:0]] <= q_head.thr;
         end
      end
      slow_ff   <= slow_in;
      cur_ff    <= cur_in;
      bits_ff   <= bits_in;
      charge_ff <= charge_in;
   end

endmodule

>>> design/cbpc_checker.sv
// ----------------------------------------------------------------------------
// cbpc_checker
// Port-level checks of the cell balancer, bound to the top level.
// ----------------------------------------------------------------------------
module cbpc_checker
   import cbpc_pkg::*;
#(
   parameter int CELLS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     full,
   input  logic                     empty,
   input  logic                     pop,
   input  logic [MAP_W-1:0]         rsp_discharger_bits,
   input  logic signed [ACC_W-1:0]  rsp_charge_value
);

   localparam int MAP_CELLS = (CELLS < MAP_W) ? CELLS : MAP_W;
   localparam logic [MAP_W-1:0] MAP_MASK = MAP_W'((1 << MAP_CELLS) - 1);

   // reset leaves no result waiting
   assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

   // reset leaves the request queue open
   assert property (@(posedge clock) reset |=> !full)
      else $error("request side full after reset");

   // a waiting result holds until popped
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_discharger_bits)
                            && $stable(rsp_charge_value)))
      else $error("waiting result changed before pop");

   // no discharger bit for an absent cell
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_discharger_bits & ~MAP_MASK) == '0))
      else $error("discharger bit set for absent cell");

endmodule

bind cell_balancer_pwm_coulomb cbpc_checker #(
   .CELLS (CELLS)
) u_cbpc_checker (
   .clock               (clock),
   .reset               (reset),
   .full                (full),
   .empty               (empty),
   .pop                 (pop),
   .rsp_discharger_bits (rsp_discharger_bits),
   .rsp_charge_value    (rsp_charge_value)
);
